/* rtl/conv3_pkg.sv */
package conv3_pkg;

  localparam int PIX_W    = 8;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = PIX_W + 1 + COEF_W;
  localparam int PART_W   = PROD_W + 1;
  localparam int SUM_W    = PART_W + 2;
  localparam int GAIN_W   = 24;
  localparam int SCALED_W = SUM_W - 1 + GAIN_W;
  localparam int ROUND_SH = 16;
  localparam int HEIGHT_W = 16;
  localparam int FWIDTH_W = 11;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam logic [23:0]         KERNEL_RESET = 24'd65793;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd7282;
  localparam logic [FWIDTH_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam int                  MIN_DIM      = 3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [2:0] REG_GAIN          = 3'd3;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] bot;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
  } column_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_pair_t;

  typedef struct packed {
    logic res;
    logic border;
    logic last;
  } ctl_t;

  function automatic logic signed [PROD_W-1:0] pix_mul(logic [PIX_W-1:0] p,
                                                       logic [COEF_W-1:0] c);
    return $signed({1'b0, p}) * $signed(c);
  endfunction

endpackage

/* rtl/conv3_cell.sv */
module conv3_cell import conv3_pkg::*; (
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic                     mac_en,
  input  column_t                  col_in,
  input  column_t                  coef,
  output column_t                  col_out,
  output logic signed [PART_W-1:0] part
);

  column_t                  pix;
  logic signed [PART_W-1:0] part_next;

  always_comb begin
    part_next = PART_W'(pix_mul(pix.top, coef.top))
              + PART_W'(pix_mul(pix.mid, coef.mid))
              + PART_W'(pix_mul(pix.bot, coef.bot));
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix <= col_in;
    end
    if (mac_en) begin
      part <= part_next;
    end
  end

  assign col_out = pix;

endmodule

/* rtl/conv3_linebuf.sv */
module conv3_linebuf import conv3_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_pair_t    wr_data,
  output line_pair_t    rd_data
);

  line_pair_t mem [DEPTH];
  line_pair_t rd_q;
  line_pair_t byp_data;
  logic       byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

/* rtl/convolution_3x3_filter.sv */
// 3x3 convolution filter over a raster-order stream of 8-bit gray pixels.
// input items: s_axis_tdata carries the pixel, s_axis_tuser[0] the command
// (0 pixel, 1 flush) and s_axis_tuser[1] the start-of-frame mark, which on a
// pixel restarts all position counters. results: m_axis_tdata is the filtered
// or, at the image border, the original pixel; m_axis_tlast marks the final
// result of a frame. flush items push the last width+1 results out.
// kernel rows, gain and frame size sit on the register port at 4*index; the
// user must change them only while the filter is idle (not enforced here).
// throughput: one item per clock while s_axis_tready is high. each result
// belongs to the item accepted eff_w+1 items earlier; once the item which
// releases it is taken it passes a line store read, the window shift, the
// column products in the three window cells, the column sum, the gain
// multiply and the rounding into the output register.
// reset clears the counters, the pipeline and the registers to their defaults;
// the line stores need no clearing. when m_axis_tready is low the result holds
// in the output register, the stages behind it keep filling, and s_axis_tready
// drops only once every stage is full.
module convolution_3x3_filter import conv3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel_in
  input  logic [1:0]  s_axis_tuser,   // command, start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // pixel_out
  output logic        m_axis_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > FWIDTH_W) ? CW + 1 : FWIDTH_W;

  // registers
  logic [23:0]         kernel_top, kernel_middle, kernel_bottom;
  logic [GAIN_W-1:0]   gain;
  logic [FWIDTH_W-1:0] frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_top    <= KERNEL_RESET;
      kernel_middle <= KERNEL_RESET;
      kernel_bottom <= KERNEL_RESET;
      gain          <= GAIN_RESET;
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KERNEL_TOP:    kernel_top    <= pwdata[23:0];
        REG_KERNEL_MIDDLE: kernel_middle <= pwdata[23:0];
        REG_KERNEL_BOTTOM: kernel_bottom <= pwdata[23:0];
        REG_GAIN:          gain          <= pwdata[GAIN_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= pwdata[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KERNEL_TOP:    prdata = {8'd0, kernel_top};
      REG_KERNEL_MIDDLE: prdata = {8'd0, kernel_middle};
      REG_KERNEL_BOTTOM: prdata = {8'd0, kernel_bottom};
      REG_GAIN:          prdata = {8'd0, gain};
      REG_FRAME_WIDTH:   prdata = {21'd0, frame_width};
      REG_FRAME_HEIGHT:  prdata = {16'd0, frame_height};
      default:           prdata = '0;
    endcase
  end

  // effective frame size
  logic [EW-1:0]       eff_w, fw_ext;
  logic [HEIGHT_W-1:0] eff_h;

  assign fw_ext = EW'(frame_width);
  always_comb begin
    if (fw_ext < EW'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (frame_height < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : frame_height;
  end

  // pipeline flow
  logic v1, v2, v3, v4, v5, out_valid;
  logic free1, free2, free3, free4, free5, free_out;
  logic accept;

  assign free_out      = !out_valid || m_axis_tready;
  assign free5         = !v5 || free_out;
  assign free4         = !v4 || free5;
  assign free3         = !v3 || free4;
  assign free2         = !v2 || free3;
  assign free1         = !v1 || free2;
  assign s_axis_tready = free1;
  assign accept        = s_axis_tvalid && free1;

  // position counters
  logic [CW-1:0]       in_column, in_column_next, out_column, out_column_next;
  logic [HEIGHT_W-1:0] out_row, out_row_next;
  logic [EW-1:0]       lag_count, lag_count_next;
  logic                is_pix, sof;
  logic [CW-1:0]       col, ocol_c;
  logic [HEIGHT_W-1:0] orow_c;
  logic [EW-1:0]       lag_c, colp1, ocp1;
  logic [HEIGHT_W:0]   orp1;
  logic                emit, col_wrap, row_end;
  ctl_t                ctl0;

  assign is_pix = (s_axis_tuser[0] == CMD_PIXEL);
  assign sof    = is_pix && s_axis_tuser[1];

  always_comb begin
    col      = sof ? '0 : in_column;
    ocol_c   = sof ? '0 : out_column;
    orow_c   = sof ? '0 : out_row;
    lag_c    = sof ? '0 : lag_count;
    colp1    = EW'(col) + EW'(1);
    ocp1     = EW'(ocol_c) + EW'(1);
    orp1     = (HEIGHT_W + 1)'(orow_c) + (HEIGHT_W + 1)'(1);
    col_wrap = ocp1 >= eff_w;
    row_end  = orp1 >= {1'b0, eff_h};
    emit     = {1'b0, lag_c} >= ({1'b0, eff_w} + (EW + 1)'(1));

    in_column_next = (colp1 >= eff_w) ? '0 : colp1[CW-1:0];
    lag_count_next = emit ? lag_c : lag_c + EW'(1);

    ctl0.res    = emit && (orow_c < eff_h);
    ctl0.border = (orow_c == '0) || row_end || (ocol_c == '0) || col_wrap;
    ctl0.last   = row_end && col_wrap;

    out_column_next = ocol_c;
    out_row_next    = orow_c;
    if (ctl0.res) begin
      out_column_next = col_wrap ? '0 : ocp1[CW-1:0];
      if (ctl0.last) begin
        out_row_next = eff_h;
      end else if (col_wrap) begin
        out_row_next = orp1[HEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      out_column <= '0;
      out_row    <= '0;
      lag_count  <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      lag_count  <= lag_count_next;
    end
  end

  // stage 1: line store read
  logic [PIX_W-1:0] pix1;
  logic             is_pix1;
  logic [CW-1:0]    addr1;
  ctl_t             ctl1, ctl2, ctl3, ctl4, ctl5;
  line_pair_t       lb_rd, lb_wr;
  logic             lb_wr_en, shift_en;

  assign shift_en    = v1 && free2;
  assign lb_wr_en    = shift_en && is_pix1;
  assign lb_wr.upper = lb_rd.lower;
  assign lb_wr.lower = pix1;

  conv3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (lb_wr_en),
    .wr_addr (addr1),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  always_ff @(posedge clk) begin
    if (free1) begin
      pix1    <= is_pix ? s_axis_tdata : '0;
      is_pix1 <= is_pix;
      addr1   <= col;
      ctl1    <= ctl0;
    end
  end

  // stage 2 and 3: window cells
  column_t                  new_col;
  column_t                  cell_col  [3];
  column_t                  cell_coef [3];
  logic signed [PART_W-1:0] cell_part [3];

  assign new_col.top = lb_rd.upper;
  assign new_col.mid = lb_rd.lower;
  assign new_col.bot = pix1;

  for (genvar c = 0; c < 3; c++) begin : g_cell
    assign cell_coef[c].top = kernel_top[8*c +: 8];
    assign cell_coef[c].mid = kernel_middle[8*c +: 8];
    assign cell_coef[c].bot = kernel_bottom[8*c +: 8];
    if (c == 2) begin : g_head
      conv3_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .mac_en   (free3),
        .col_in   (new_col),
        .coef     (cell_coef[c]),
        .col_out  (cell_col[c]),
        .part     (cell_part[c])
      );
    end else begin : g_body
      conv3_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .mac_en   (free3),
        .col_in   (cell_col[c+1]),
        .coef     (cell_coef[c]),
        .col_out  (cell_col[c]),
        .part     (cell_part[c])
      );
    end
  end

  logic [PIX_W-1:0] centre3, centre4, centre5;

  always_ff @(posedge clk) begin
    if (free2) begin
      ctl2 <= ctl1;
    end
    if (free3) begin
      ctl3    <= ctl2;
      centre3 <= cell_col[1].mid;
    end
  end

  // stage 4: column sum
  logic signed [SUM_W-1:0] sum3;
  logic [SUM_W-2:0]        sum_pos4;

  assign sum3 = SUM_W'(cell_part[0]) + SUM_W'(cell_part[1]) + SUM_W'(cell_part[2]);

  always_ff @(posedge clk) begin
    if (free4) begin
      ctl4     <= ctl3;
      centre4  <= centre3;
      sum_pos4 <= (sum3 > 0) ? sum3[SUM_W-2:0] : '0;
    end
  end

  // stage 5: gain
  logic [SCALED_W-1:0] prod5;

  always_ff @(posedge clk) begin
    if (free5) begin
      ctl5    <= ctl4;
      centre5 <= centre4;
      prod5   <= SCALED_W'(sum_pos4) * SCALED_W'(gain);
    end
  end

  // rounding, clamp and output register
  logic [SCALED_W-ROUND_SH-1:0] whole;
  logic                         sat;
  logic [PIX_W-1:0]             scaled;

  assign whole  = prod5[SCALED_W-1:ROUND_SH];
  assign sat    = (|whole[SCALED_W-ROUND_SH-1:PIX_W]) || (whole[PIX_W-1:0] == PIX_MAX);
  assign scaled = sat ? PIX_MAX : whole[PIX_W-1:0] + PIX_W'(prod5[ROUND_SH-1]);

  always_ff @(posedge clk) begin
    if (free_out && v5 && ctl5.res) begin
      m_axis_tdata <= ctl5.border ? centre5 : scaled;
      m_axis_tlast <= ctl5.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) v1 <= s_axis_tvalid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
      if (free5) v5 <= v4;
      if (free_out) out_valid <= v5 && ctl5.res;
    end
  end

  assign m_axis_tvalid = out_valid;

`ifndef NO_ASSERTIONS
  a_rise_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(v5 && ctl5.res))
    else $error("result shown without a result in the last stage");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && v1 && v2 && v3 && v4 && v5) |-> !s_axis_tready)
    else $error("item taken while every stage is full and stalled");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted item lost before the line store stage");

  a_lag_bounded: assert property (@(posedge clk) disable iff (rst)
    {1'b0, lag_count} <= (EW + 1)'(MAX_WIDTH + 1))
    else $error("lag count beyond the widest line");
`endif

endmodule

/* test/tb_convolution_3x3_filter.sv */
module tb_convolution_3x3_filter;
  import conv3_pkg::*;

  localparam int LINE_MAX = 1024;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } gray_result_t;

  typedef struct packed {
    logic         cmd;
    logic [7:0]   px;
    logic         sof;
    logic         typed;
    gray_result_t want;
  } stim_row_t;

  // two 3x3 frames, then a start mark that drops the tail of the second
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{CMD_PIXEL, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h00, 1'b0, 1'b1, '{8'hFF, 1'b0}},
    '{CMD_PIXEL, 8'h55, 1'b0, 1'b1, '{8'h01, 1'b0}},
    '{CMD_PIXEL, 8'hAA, 1'b0, 1'b1, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h80, 1'b0, 1'b1, '{8'hFF, 1'b0}},  // clamped high
    '{CMD_FLUSH, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0}},  // start mark ignored
    '{CMD_PIXEL, 8'h33, 1'b0, 1'b1, '{8'h55, 1'b0}},
    '{CMD_FLUSH, 8'hC3, 1'b0, 1'b1, '{8'hAA, 1'b0}},
    '{CMD_FLUSH, 8'h00, 1'b0, 1'b1, '{8'h80, 1'b1}},
    '{CMD_PIXEL, 8'h44, 1'b0, 1'b0, '{8'h00, 1'b0}},  // past end of frame
    '{CMD_PIXEL, 8'h10, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h20, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h30, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{CMD_PIXEL, 8'h00, 1'b0, 1'b1, '{8'h10, 1'b0}},
    '{CMD_PIXEL, 8'hFF, 1'b0, 1'b1, '{8'h20, 1'b0}},
    '{CMD_PIXEL, 8'h40, 1'b0, 1'b1, '{8'h30, 1'b0}},
    '{CMD_PIXEL, 8'h50, 1'b0, 1'b1, '{8'hFF, 1'b0}},
    '{CMD_PIXEL, 8'h60, 1'b0, 1'b1, '{8'h00, 1'b0}},  // negative sum
    '{CMD_PIXEL, 8'h7F, 1'b1, 1'b0, '{8'h00, 1'b0}}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // pixel_in
  logic [1:0]  s_axis_tuser = '0;   // command, start_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // pixel_out
  logic        m_axis_tlast;

  convolution_3x3_filter #(.MAX_WIDTH(LINE_MAX)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // filter state as the testbench sees it
  logic [23:0]   k_top = KERNEL_RESET;
  logic [23:0]   k_mid = KERNEL_RESET;
  logic [23:0]   k_bot = KERNEL_RESET;
  logic [23:0]   gain_reg = GAIN_RESET;
  logic [10:0]   fr_width = WIDTH_RESET;
  logic [15:0]   fr_height = HEIGHT_RESET;
  logic [7:0]    row_above_mem [LINE_MAX] = '{default: '0};
  logic [7:0]    row_prev_mem [LINE_MAX] = '{default: '0};
  logic [7:0]    win [9] = '{default: '0};
  int unsigned   in_col = 0, in_row = 0, out_col = 0, out_row = 0, lag = 0;

  gray_result_t  expected_gray [$];
  gray_result_t  head;
  int            mismatches = 0;
  int            items_sent = 0;
  int            send_idle = 0;
  int            recv_idle = 0;
  int            hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("[convolution_3x3_filter] ERROR");
    $finish;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = fr_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (fr_height < MIN_DIM) ? MIN_DIM : fr_height;
  endfunction

  function automatic logic [7:0] weighted_gray();
    int                acc;
    longint            scaled;
    logic signed [7:0] cf;
    logic [23:0]       krow;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      krow = (r == 0) ? k_top : (r == 1) ? k_mid : k_bot;
      for (int c = 0; c < 3; c++) begin
        cf = krow[8*c +: 8];
        acc += int'(win[r*3+c]) * int'(cf);
      end
    end
    if (acc <= 0) return '0;
    scaled = (longint'(acc) * longint'(gain_reg) + 64'sd32768) >>> 16;
    return (scaled > 255) ? PIX_MAX : scaled[7:0];
  endfunction

  task automatic filter_step(input logic cmd, input logic [7:0] px_in, input logic sof,
                             output bit emit, output gray_result_t res);
    logic [7:0]  px, top, mid;
    int unsigned w, h, col;
    bit          border;
    px = (cmd == CMD_PIXEL) ? px_in : '0;
    w = eff_width();
    h = eff_height();
    col = in_col;
    res = '0;
    if (cmd == CMD_PIXEL && sof) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      lag = 0;
      col = 0;
    end
    top = row_above_mem[col];
    mid = row_prev_mem[col];
    if (cmd == CMD_PIXEL) begin
      row_above_mem[col] = mid;
      row_prev_mem[col] = px;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    in_col = col + 1;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;
    end
    emit = lag >= w + 1;
    if (!emit) lag++;
    if (!emit || out_row >= h) begin
      emit = 1'b0;
      return;
    end
    border = out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w;
    res.value = border ? win[4] : weighted_gray();
    res.last = out_row + 1 >= h && out_col + 1 >= w;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (res.last) out_row = h;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40)
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_KERNEL_TOP:    k_top = val[23:0];
      REG_KERNEL_MIDDLE: k_mid = val[23:0];
      REG_KERNEL_BOTTOM: k_bot = val[23:0];
      REG_GAIN:          gain_reg = val[23:0];
      REG_FRAME_WIDTH:   fr_width = val[10:0];
      REG_FRAME_HEIGHT:  fr_height = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(logic cmd, logic [7:0] px, logic sof, logic typed,
                           gray_result_t typed_res);
    bit           emit;
    gray_result_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= {sof, cmd};
    do @(posedge clk); while (!s_axis_tready);
    filter_step(cmd, px, sof, emit, res);
    if (emit) expected_gray.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_gray.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (12) @(posedge clk);
  endtask

  // one frame, mostly well formed, sometimes cut short, overrun or pure noise
  task automatic run_frame();
    int unsigned w, h, total, npix, drain, extra, kind, n;
    logic        c;
    w = eff_width();
    h = eff_height();
    total = w * h;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      n = $urandom_range(1, 3 * w);
      repeat (n)
        send_item($urandom_range(0, 1), $urandom_range(0, 255),
                  $urandom_range(0, 7) == 0, 1'b0, '0);
      return;
    end
    npix = total;
    drain = w + 1;
    extra = 0;
    if (kind == 7) begin
      npix = $urandom_range(1, total);
      drain = $urandom_range(0, w);
    end
    if (kind == 8) extra = $urandom_range(1, 2 * w);
    if (total > 150) begin
      npix = $urandom_range(2 * w + 2, 150);
      drain = 0;
    end
    for (int i = 0; i < npix; i++) begin
      c = (i > 0 && $urandom_range(0, 24) == 0) ? CMD_FLUSH : CMD_PIXEL;
      send_item(c, $urandom_range(0, 255),
                i == 0 || (c == CMD_FLUSH && $urandom_range(0, 1) == 1), 1'b0, '0);
    end
    repeat (drain)
      send_item(CMD_FLUSH, $urandom_range(0, 255), $urandom_range(0, 1), 1'b0, '0);
    repeat (extra)
      send_item(CMD_PIXEL, $urandom_range(0, 255), 1'b0, 1'b0, '0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_gray.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        head = expected_gray.pop_front();
        if (m_axis_tdata !== head.value) report_mismatch("pixel_out", m_axis_tdata, head.value);
        if (m_axis_tlast !== head.last) report_mismatch("last_of_frame", m_axis_tlast, head.last);
      end
    end
  end

  initial begin
    int          phase_start;
    bit          paused;
    logic [23:0] kt, km, kb, gn;
    logic [31:0] wv, hv;
    paused = 1'b0;
    send_idle = 22;
    recv_idle = 48;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both line stores at full width before any frame start
    reg_write(REG_FRAME_WIDTH, 32'd2047);
    reg_write(REG_FRAME_HEIGHT, 32'd0);
    for (int i = 0; i < 3 * LINE_MAX; i++)
      send_item(CMD_PIXEL, $urandom_range(0, 255), 1'b0, 1'b0, '0);
    repeat (LINE_MAX + 1)
      send_item(CMD_FLUSH, $urandom_range(0, 255), 1'b0, 1'b0, '0);
    settle();

    reg_write(REG_KERNEL_TOP, 32'h0);
    reg_write(REG_KERNEL_MIDDLE, 32'h00817F81);
    reg_write(REG_KERNEL_BOTTOM, 32'h0);
    reg_write(REG_GAIN, 32'h00FFFFFF);
    reg_write(REG_FRAME_WIDTH, 32'd1);
    reg_write(REG_FRAME_HEIGHT, 32'd3);
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].sof,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle = (ph < 2) ? 22 : (ph < 4) ? 48 : 0;
      recv_idle = (ph < 2) ? 48 : (ph < 4) ? 22 : 0;
      kt = $urandom;
      km = $urandom;
      kb = $urandom;
      gn = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 16000));
      wv = $urandom_range(0, 12);
      hv = $urandom_range(0, 7);
      case (ph)
        1: begin
          kt = 24'hFFFFFF;
          km = 24'hFFFFFF;
          kb = 24'hFFFFFF;
          gn = 24'hFFFFFF;
          wv = 3;
          hv = 32'hFFFF;
        end
        2: begin
          kt = 24'h7F7F7F;
          km = 24'h7F7F7F;
          kb = 24'h7F7F7F;
          gn = 24'h0;
        end
        3: begin
          kt = 24'h808080;
          km = 24'h808080;
          kb = 24'h808080;
        end
        default: ;
      endcase
      reg_write(REG_KERNEL_TOP, {8'h0, kt});
      reg_write(REG_KERNEL_MIDDLE, {8'h0, km});
      reg_write(REG_KERNEL_BOTTOM, {8'h0, kb});
      reg_write(REG_GAIN, {8'h0, gn});
      reg_write(REG_FRAME_WIDTH, wv);
      reg_write(REG_FRAME_HEIGHT, hv);
      // long output stall while items keep coming
      if (ph == 1) hold_left = 400;
      phase_start = items_sent;
      while (items_sent - phase_start < 240) begin
        run_frame();
        if (ph == 3 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[convolution_3x3_filter] OK");
    end else begin
      $display("[convolution_3x3_filter] ERROR");
    end
    $finish;
  end

endmodule
